### rtl/core/mtpc_pkg.sv
`default_nettype none

package mtpc_pkg;

  // Sizing
  localparam int NumButtons = 8;
  localparam int BtnSelW    = (NumButtons > 1) ? $clog2(NumButtons) : 1;
  localparam int BtnW       = 3;
  localparam int TimeW      = 32;
  localparam int CfgW       = 16;
  localparam int CfgIdxW    = 2;

  // Result queue
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgLongPress = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTapWindow = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHoldoff   = 2'd2;

  // Register reset values
  localparam logic [CfgW-1:0] LongPressRst = 16'd1000;
  localparam logic [CfgW-1:0] TapWindowRst = 16'd300;
  localparam logic [CfgW-1:0] HoldoffRst   = 16'd1000;

  typedef enum logic [1:0] {
    GestShort  = 2'd0,
    GestDouble = 2'd1,
    GestTriple = 2'd2,
    GestLong   = 2'd3
  } gesture_e;

  typedef struct packed {
    logic [CfgW-1:0] long_press;
    logic [CfgW-1:0] tap_window;
    logic [CfgW-1:0] holdoff;
  } cfg_t;

  // Per-button tracking state
  typedef struct packed {
    logic             prev_level;
    logic [TimeW-1:0] press_time;
    logic [TimeW-1:0] first_tap;
    logic [TimeW-1:0] second_tap;
    logic             short_pending;
    logic [TimeW-1:0] short_expiry;
    logic             double_pending;
    logic [TimeW-1:0] double_expiry;
  } btn_state_t;

  typedef struct packed {
    logic [BtnW-1:0] button;
    gesture_e        gesture;
    logic            last;
  } result_t;

  // Up to two results of one poll, in emission order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } res_pair_t;

endpackage

`default_nettype wire

### rtl/core/multi_tap_press_classifier.sv
`default_nettype none

// Channel  | Handshake              | Payload
// ---------+------------------------+-----------------------------------------
// poll in  | in_valid_i/in_ready_o  | button_index_i, level_i, now_ms_i
// gesture  | out_valid_o/out_ready_i| event_button_o, gesture_o, last_o
// config   | cfg_we_i (no wait)     | cfg_addr_i, cfg_wdata_i
//
// One poll per cycle unless stalled: a poll in the stage register is classified
// there against its button's flops, and its 0..2 results land in a 4-entry queue.
// A poll is captured in the stage register and its results in the queue storage
// before the first of them is on the gesture outputs.
// Results drain at one per cycle while out_ready_i is high; the stage stalls only when
// the queue lacks room for two entries, as when gestures outpace the receiver.
// Reset puts every button and register at its reset value at once (no sweep).
module multi_tap_press_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // poll channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mtpc_pkg::BtnW-1:0]       button_index_i,
  input  logic                            level_i,
  input  logic [mtpc_pkg::TimeW-1:0]      now_ms_i,
  // gesture channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mtpc_pkg::BtnW-1:0]       event_button_o,
  output logic [1:0]                      gesture_o,
  output logic                            last_o,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [mtpc_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  logic [mtpc_pkg::CfgW-1:0]       cfg_wdata_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  mtpc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        mtpc_pkg::CfgLongPress: cfg_d.long_press = cfg_wdata_i;
        mtpc_pkg::CfgTapWindow: cfg_d.tap_window = cfg_wdata_i;
        mtpc_pkg::CfgHoldoff:   cfg_d.holdoff    = cfg_wdata_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press <= mtpc_pkg::LongPressRst;
      cfg_q.tap_window <= mtpc_pkg::TapWindowRst;
      cfg_q.holdoff    <= mtpc_pkg::HoldoffRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage register: holds one accepted poll while it is classified
  // ---------------------------------------------------------------------------
  logic                          s_valid_q;
  logic [mtpc_pkg::BtnW-1:0]     s_btn_q;
  logic                          s_level_q;
  logic [mtpc_pkg::TimeW-1:0]    s_now_q;
  logic                          room2;
  logic                          process;
  logic                          in_accept;

  // The queue room flag is registered state, so ready has no path from out_ready_i.
  assign process    = s_valid_q && room2;
  assign in_ready_o = !s_valid_q || process;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s_btn_q   <= button_index_i;
      s_level_q <= level_i;
      s_now_q   <= now_ms_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-button state and the hold-off timer
  // ---------------------------------------------------------------------------
  mtpc_pkg::btn_state_t            btn_q [mtpc_pkg::NumButtons];
  mtpc_pkg::btn_state_t            st_cur;
  mtpc_pkg::btn_state_t            st_nxt;
  mtpc_pkg::res_pair_t             res;
  logic [mtpc_pkg::BtnSelW-1:0]    sel;
  logic                            in_range;
  logic                            commit;
  logic                            started_q;
  logic [mtpc_pkg::TimeW-1:0]      start_time_q;
  logic [1:0]                      push_cnt;

  // Indexes past the last button are dropped without touching any state.
  assign in_range = int'(s_btn_q) < mtpc_pkg::NumButtons;
  assign sel      = mtpc_pkg::BtnSelW'(s_btn_q);
  assign st_cur   = btn_q[sel];
  assign commit   = process && in_range;
  assign push_cnt = commit ? res.count : 2'd0;

  mtpc_classify u_classify (
    .st_i         (st_cur),
    .button_i     (s_btn_q),
    .level_i      (s_level_q),
    .now_i        (s_now_q),
    .cfg_i        (cfg_q),
    .started_i    (started_q),
    .start_time_i (start_time_q),
    .st_o         (st_nxt),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mtpc_pkg::NumButtons; i++) begin
        btn_q[i] <= '{prev_level: 1'b1, default: '0};
      end
      started_q    <= 1'b0;
      start_time_q <= '0;
    end else if (commit) begin
      btn_q[sel] <= st_nxt;
      // first in-range poll opens the hold-off window
      if (!started_q) begin
        started_q    <= 1'b1;
        start_time_q <= s_now_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------------
  mtpc_pkg::result_t out_res;

  mtpc_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .wdata0_i   (res.first),
    .wdata1_i   (res.second),
    .room2_o    (room2),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .rdata_o    (out_res)
  );

  assign event_button_o = out_res.button;
  assign gesture_o      = out_res.gesture;
  assign last_o         = out_res.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_q && !process) |=> (s_valid_q && $stable(s_now_q) && $stable(s_btn_q)))
    else $error("stalled poll left the stage register");

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("hold-off start flag dropped");

  a_commit_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> started_q)
    else $error("processed poll did not start the hold-off timer");

  a_two_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt == 2'd2) |-> (!res.first.last && res.second.last))
    else $error("last flag misplaced on a result pair");

endmodule

`default_nettype wire

### rtl/core/mtpc_classify.sv
`default_nettype none

// Combinational classification of one poll against one button's state.
module mtpc_classify (
  input  mtpc_pkg::btn_state_t            st_i,
  input  logic [mtpc_pkg::BtnW-1:0]       button_i,
  input  logic                            level_i,
  input  logic [mtpc_pkg::TimeW-1:0]      now_i,
  input  mtpc_pkg::cfg_t                  cfg_i,
  input  logic                            started_i,
  input  logic [mtpc_pkg::TimeW-1:0]      start_time_i,
  output mtpc_pkg::btn_state_t            st_o,
  output mtpc_pkg::res_pair_t             res_o
);

  logic [mtpc_pkg::TimeW-1:0] ref_start;
  logic [mtpc_pkg::TimeW-1:0] since_start;
  logic [mtpc_pkg::TimeW-1:0] dur;
  logic [mtpc_pkg::TimeW-1:0] since_first;
  logic [mtpc_pkg::TimeW-1:0] since_second;
  logic [mtpc_pkg::TimeW-1:0] win;
  logic [mtpc_pkg::TimeW-1:0] expiry_new;
  logic                       active;
  logic                       released;
  logic                       skip;
  logic                       cls_fire;
  mtpc_pkg::gesture_e         cls_gest;
  logic                       short_fire;
  logic                       double_fire;
  mtpc_pkg::btn_state_t       st;

  assign ref_start    = started_i ? start_time_i : now_i;
  assign since_start  = now_i - ref_start;
  assign active       = since_start >= mtpc_pkg::TimeW'(cfg_i.holdoff);
  assign released     = !st_i.prev_level && level_i;
  assign dur          = now_i - st_i.press_time;
  assign since_first  = now_i - st_i.first_tap;
  assign since_second = now_i - st_i.second_tap;
  assign win          = mtpc_pkg::TimeW'(cfg_i.tap_window);
  assign expiry_new   = now_i + win;

  always_comb begin
    st          = st_i;
    st.prev_level = level_i;
    skip        = 1'b1;
    cls_fire    = 1'b0;
    cls_gest    = mtpc_pkg::GestLong;
    short_fire  = 1'b0;
    double_fire = 1'b0;
    if (active) begin
      skip = 1'b0;
      if (st_i.prev_level && !level_i) begin
        st.press_time = now_i;
      end
      if (released) begin
        if (st_i.press_time == '0) begin
          // release with no press on record: just note the time
          st.press_time = now_i;
          skip = 1'b1;
        end else if (dur >= mtpc_pkg::TimeW'(cfg_i.long_press)) begin
          st.first_tap = '0; st.second_tap = '0;
          st.short_pending = 1'b0; st.double_pending = 1'b0;
          cls_fire = 1'b1;
          cls_gest = mtpc_pkg::GestLong;
        end else if (st_i.double_pending && (since_second <= win)) begin
          st.first_tap = '0; st.second_tap = '0;
          st.short_pending = 1'b0; st.double_pending = 1'b0;
          cls_fire = 1'b1;
          cls_gest = mtpc_pkg::GestTriple;
        end else if (since_first <= win) begin
          st.first_tap      = '0;
          st.short_pending  = 1'b0;
          st.second_tap     = now_i;
          st.double_pending = 1'b1;
          st.double_expiry  = expiry_new;
        end else begin
          st.first_tap     = now_i;
          st.short_pending = 1'b1;
          st.short_expiry  = expiry_new;
        end
      end
      if (!skip) begin
        // plain unsigned expiry compares, no wrap handling
        short_fire  = st.short_pending && (now_i >= st.short_expiry);
        double_fire = st.double_pending && (now_i >= st.double_expiry);
        if (short_fire) begin
          st.short_pending = 1'b0;
        end
        if (double_fire) begin
          st.double_pending = 1'b0;
        end
      end
    end
  end

  // A classified release clears the pending flags, so it never pairs with an expiry.
  always_comb begin
    res_o.first.button   = button_i;
    res_o.second.button  = button_i;
    res_o.second.gesture = mtpc_pkg::GestDouble;
    res_o.second.last    = 1'b1;
    if (cls_fire) begin
      res_o.first.gesture = cls_gest;
    end else if (short_fire) begin
      res_o.first.gesture = mtpc_pkg::GestShort;
    end else begin
      res_o.first.gesture = mtpc_pkg::GestDouble;
    end
    if (short_fire && double_fire) begin
      res_o.count      = 2'd2;
      res_o.first.last = 1'b0;
    end else if (cls_fire || short_fire || double_fire) begin
      res_o.count      = 2'd1;
      res_o.first.last = 1'b1;
    end else begin
      res_o.count      = 2'd0;
      res_o.first.last = 1'b1;
    end
  end

  assign st_o = st;

endmodule

`default_nettype wire

### rtl/core/mtpc_res_fifo.sv
`default_nettype none

// Result queue: up to two writes and one read per cycle.
module mtpc_res_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_cnt_i,
  input  mtpc_pkg::result_t    wdata0_i,
  input  mtpc_pkg::result_t    wdata1_i,
  output logic                 room2_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output mtpc_pkg::result_t    rdata_o
);

  mtpc_pkg::result_t                mem_q [mtpc_pkg::FifoDepth];
  logic [mtpc_pkg::FifoPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [mtpc_pkg::FifoPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [mtpc_pkg::FifoCntW-1:0]    count_q, count_d;
  logic [mtpc_pkg::FifoPtrW-1:0]    wr_ptr_nxt;
  logic                             pop;

  assign valid_o    = count_q != '0;
  assign pop        = valid_o && ready_i;
  assign rdata_o    = mem_q[rd_ptr_q];
  assign room2_o    = count_q <= mtpc_pkg::FifoCntW'(mtpc_pkg::FifoDepth - 2);
  assign wr_ptr_nxt = wr_ptr_q + mtpc_pkg::FifoPtrW'(1);
  assign wr_ptr_d   = wr_ptr_q + mtpc_pkg::FifoPtrW'(push_cnt_i);
  assign rd_ptr_d   = rd_ptr_q + mtpc_pkg::FifoPtrW'(pop);
  assign count_d    = count_q + mtpc_pkg::FifoCntW'(push_cnt_i)
                      - mtpc_pkg::FifoCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wdata0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= wdata1_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mtpc_pkg::FifoCntW'(mtpc_pkg::FifoDepth))
    else $error("result queue overflow");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[mtpc_pkg::FifoPtrW-1:0])
    else $error("result queue pointers disagree with count");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i == 2'd0 && !pop) |=> $stable(count_q))
    else $error("result queue count moved while idle");

endmodule

`default_nettype wire

### test/multi_tap_press_classifier_tb.sv
module multi_tap_press_classifier_tb;
  import mtpc_pkg::*;

  // Run sizing. The hard cycle limit is far above the slowest legal run:
  // ~1450 polls, each with two gestures, each waiting out long receiver stalls.
  localparam int CycleLimit    = 800_000;
  localparam int DrainLimit    = 20_000;
  localparam int SettleCycles  = 8;
  localparam int PhaseCount    = 8;
  localparam int PollsPerPhase = 178;
  localparam int RxHoldCycles  = 400;

  // One row of the directed stimulus. Rows with known_result set carry their
  // expected gesture count and kind; the others are checked via the predictor.
  typedef struct {
    logic [BtnW-1:0]  btn;
    logic             lvl;
    logic [TimeW-1:0] now;
    bit               known_result;
    int               n_known;
    gesture_e         g_known;
  } poll_row_t;

  // DUT pins, all inputs at known values from time zero
  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [BtnW-1:0]   button_index_i = '0;
  logic              level_i        = 1'b1;
  logic [TimeW-1:0]  now_ms_i       = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [BtnW-1:0]   event_button_o;
  logic [1:0]        gesture_o;
  logic              last_o;
  logic              cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr_i    = '0;
  logic [CfgW-1:0]   cfg_wdata_i    = '0;

  // Shadow of the setting registers
  logic [CfgW-1:0]   set_long;
  logic [CfgW-1:0]   set_window;
  logic [CfgW-1:0]   set_holdoff;

  // Predicted per-button tap tracking
  logic              lvl_prev     [NumButtons];
  logic [TimeW-1:0]  t_press      [NumButtons];
  logic [TimeW-1:0]  t_first      [NumButtons];
  logic [TimeW-1:0]  t_second     [NumButtons];
  logic              short_pend   [NumButtons];
  logic [TimeW-1:0]  t_short_exp  [NumButtons];
  logic              double_pend  [NumButtons];
  logic [TimeW-1:0]  t_double_exp [NumButtons];
  logic [TimeW-1:0]  t_start;
  logic              poll_started;

  // Gestures still owed by the DUT, oldest first
  result_t           due_gestures [$];

  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;
  int rx_hold_left   = 0;
  int cycle_count    = 0;
  int mismatch_count = 0;
  int polls_sent     = 0;
  int gestures_seen  = 0;
  int gesture_hist [4];

  multi_tap_press_classifier u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .button_index_i (button_index_i),
    .level_i        (level_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_button_o (event_button_o),
    .gesture_o      (gesture_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the DUT hangs a handshake
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d gestures still owed", cycle_count,
               due_gestures.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < 40) $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic poll_row_t mk_poll(input logic [BtnW-1:0] b, input logic l,
                                        input logic [TimeW-1:0] t);
    poll_row_t row;
    row.btn = b;
    row.lvl = l;
    row.now = t;
    row.known_result = 1'b0;
    row.n_known = 0;
    row.g_known = GestShort;
    return row;
  endfunction

  function automatic poll_row_t mk_known(input logic [BtnW-1:0] b, input logic l,
                                         input logic [TimeW-1:0] t, input int n,
                                         input gesture_e g);
    poll_row_t row;
    row = mk_poll(b, l, t);
    row.known_result = 1'b1;
    row.n_known = n;
    row.g_known = g;
    return row;
  endfunction

  function automatic void clear_taps(input int b);
    t_first[b] = '0;
    short_pend[b] = 1'b0;
    t_second[b] = '0;
    double_pend[b] = 1'b0;
  endfunction

  // Predictor: classify one accepted poll, updating the shadow state.
  // Returns up to two gestures in emission order (short expiry before double).
  function automatic void classify_poll(input logic [BtnW-1:0] btn, input logic lvl,
                                        input logic [TimeW-1:0] now, output int n,
                                        output gesture_e g0, output gesture_e g1);
    gesture_e hits [2];
    logic was;
    logic [TimeW-1:0] since_start, held, since_first, since_second;
    logic [TimeW-1:0] hold_lim, long_lim, win_lim;
    int b;
    b = int'(btn);
    n = 0;
    hits[0] = GestShort;
    hits[1] = GestShort;
    g0 = GestShort;
    g1 = GestShort;
    hold_lim = TimeW'(set_holdoff);
    long_lim = TimeW'(set_long);
    win_lim = TimeW'(set_window);
    if (b >= NumButtons) return;

    // first poll ever opens the hold-off window
    if (!poll_started) begin
      poll_started = 1'b1;
      t_start = now;
    end
    was = lvl_prev[b];
    lvl_prev[b] = lvl;
    since_start = now - t_start;
    if (since_start < hold_lim) return;

    if (was && !lvl) t_press[b] = now;

    if (!was && lvl) begin
      // release without a recorded press only records the time
      if (t_press[b] == '0) begin
        t_press[b] = now;
        return;
      end
      held = now - t_press[b];
      since_first = now - t_first[b];
      since_second = now - t_second[b];
      if (held >= long_lim) begin
        clear_taps(b);
        hits[n] = GestLong;
        n++;
      end else if (double_pend[b] && since_second <= win_lim) begin
        clear_taps(b);
        hits[n] = GestTriple;
        n++;
      end else if (since_first <= win_lim) begin
        // second tap; a zero first-tap time counts like any other
        t_first[b] = '0;
        short_pend[b] = 1'b0;
        t_second[b] = now;
        double_pend[b] = 1'b1;
        t_double_exp[b] = now + win_lim;
      end else begin
        t_first[b] = now;
        short_pend[b] = 1'b1;
        t_short_exp[b] = now + win_lim;
      end
    end

    // expiry: plain unsigned compares, no wrap handling
    if (short_pend[b] && now >= t_short_exp[b]) begin
      short_pend[b] = 1'b0;
      hits[n] = GestShort;
      n++;
    end
    if (double_pend[b] && now >= t_double_exp[b]) begin
      double_pend[b] = 1'b0;
      hits[n] = GestDouble;
      n++;
    end
    g0 = hits[0];
    g1 = hits[1];
  endfunction

  // Offer one poll, with an optional random idle gap first. Returns right after
  // the accepting edge; valid stays high so back-to-back polls need no toggle.
  task automatic send_poll(input poll_row_t row);
    int n;
    gesture_e g0, g1;
    result_t r;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      while ($urandom_range(99) < tx_idle_pct) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    button_index_i <= row.btn;
    level_i        <= row.lvl;
    now_ms_i       <= row.now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    polls_sent++;

    classify_poll(row.btn, row.lvl, row.now, n, g0, g1);
    if (row.known_result) begin
      n = row.n_known;
      g0 = row.g_known;
    end
    for (int k = 0; k < n; k++) begin
      r.button = row.btn;
      r.gesture = (k == 0) ? g0 : g1;
      r.last = (k == n - 1);
      due_gestures.push_back(r);
    end
  endtask

  // Stop offering and let every owed gesture come out, then give a poll that
  // produced nothing time to leave the pipe.
  task automatic wait_drained();
    int spins;
    spins = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_gestures.size() != 0 && spins < DrainLimit) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgLongPress: set_long = val;
      CfgTapWindow: set_window = val;
      CfgHoldoff:   set_holdoff = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CfgW-1:0] lp, input logic [CfgW-1:0] win,
                                input logic [CfgW-1:0] hold);
    write_reg(CfgLongPress, lp);
    write_reg(CfgTapWindow, win);
    write_reg(CfgHoldoff, hold);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long forced hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Gesture checker: every output transaction against the oldest owed gesture
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin : check_gesture
      result_t want;
      gestures_seen++;
      gesture_hist[gesture_o]++;
      if (due_gestures.size() == 0) begin
        flag_mismatch($sformatf("unexpected gesture btn=%0d kind=%0d last=%0b",
                                event_button_o, gesture_o, last_o));
      end else begin
        want = due_gestures.pop_front();
        if (event_button_o !== want.button)
          flag_mismatch($sformatf("button got %0d want %0d", event_button_o, want.button));
        if (gesture_o !== want.gesture)
          flag_mismatch($sformatf("btn %0d gesture got %0d want %0d", want.button,
                                  gesture_o, want.gesture));
        if (last_o !== want.last)
          flag_mismatch($sformatf("btn %0d last got %0b want %0b", want.button,
                                  last_o, want.last));
      end
    end
  end

  initial begin
    poll_row_t        dir_rows [$];
    logic [TimeW-1:0] btn_clock [NumButtons];
    logic [CfgW-1:0]  lp, win, hold;
    logic [BtnW-1:0]  b, last_b;
    logic             lvl;
    logic [TimeW-1:0] t;
    int               r, dt, lim, lp_i, win_i;

    for (int i = 0; i < 4; i++) gesture_hist[i] = 0;
    for (int i = 0; i < NumButtons; i++) begin
      lvl_prev[i] = 1'b1;
      t_press[i] = '0;
      clear_taps(i);
      t_short_exp[i] = '0;
      t_double_exp[i] = '0;
    end
    t_start = '0;
    poll_started = 1'b0;
    set_long = LongPressRst;
    set_window = TapWindowRst;
    set_holdoff = HoldoffRst;

    // Directed part, reset settings (long 1000, window 300, hold-off 1000).
    // First poll starts the hold-off; polls inside it only track levels.
    dir_rows.push_back(mk_known(3'd0, 1'b1, 32'd5000, 0, GestShort));
    dir_rows.push_back(mk_known(3'd0, 1'b0, 32'd5100, 0, GestShort));
    dir_rows.push_back(mk_known(3'd1, 1'b0, 32'd5300, 0, GestShort));
    dir_rows.push_back(mk_known(3'd0, 1'b1, 32'd5200, 0, GestShort));
    // hold-off just over: press, then a 1500 ms hold is a long press
    dir_rows.push_back(mk_known(3'd0, 1'b0, 32'd6000, 0, GestShort));
    dir_rows.push_back(mk_known(3'd0, 1'b1, 32'd7500, 1, GestLong));
    // button 1 was pressed during hold-off: release only records the time
    dir_rows.push_back(mk_known(3'd1, 1'b1, 32'd6100, 0, GestShort));
    // single tap, emitted once its window expires
    dir_rows.push_back(mk_poll(3'd2, 1'b0, 32'd8000));
    dir_rows.push_back(mk_poll(3'd2, 1'b1, 32'd8050));
    dir_rows.push_back(mk_poll(3'd2, 1'b1, 32'd8400));
    // double tap
    dir_rows.push_back(mk_poll(3'd3, 1'b0, 32'd8500));
    dir_rows.push_back(mk_poll(3'd3, 1'b1, 32'd8520));
    dir_rows.push_back(mk_poll(3'd3, 1'b0, 32'd8600));
    dir_rows.push_back(mk_poll(3'd3, 1'b1, 32'd8650));
    dir_rows.push_back(mk_poll(3'd3, 1'b1, 32'd9000));
    // triple tap
    dir_rows.push_back(mk_poll(3'd4, 1'b0, 32'd9100));
    dir_rows.push_back(mk_poll(3'd4, 1'b1, 32'd9120));
    dir_rows.push_back(mk_poll(3'd4, 1'b0, 32'd9150));
    dir_rows.push_back(mk_poll(3'd4, 1'b1, 32'd9180));
    dir_rows.push_back(mk_poll(3'd4, 1'b0, 32'd9200));
    dir_rows.push_back(mk_poll(3'd4, 1'b1, 32'd9250));
    // near the top of time: a pending double, then a tap 301 ms after it whose
    // short expiry wraps past zero, so short and double come out of one poll
    dir_rows.push_back(mk_poll(3'd7, 1'b0, 32'hFFFF_FE2B));
    dir_rows.push_back(mk_poll(3'd7, 1'b1, 32'hFFFF_FE35));
    dir_rows.push_back(mk_poll(3'd7, 1'b0, 32'hFFFF_FE49));
    dir_rows.push_back(mk_poll(3'd7, 1'b1, 32'hFFFF_FE53));
    dir_rows.push_back(mk_poll(3'd7, 1'b0, 32'hFFFF_FF76));
    dir_rows.push_back(mk_poll(3'd7, 1'b1, 32'hFFFF_FF80));
    // early release with zero first-tap time counts as a second tap
    dir_rows.push_back(mk_poll(3'd6, 1'b0, 32'd100));
    dir_rows.push_back(mk_poll(3'd6, 1'b1, 32'd200));
    dir_rows.push_back(mk_poll(3'd6, 1'b1, 32'hFFFF_FFFF));

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_poll(dir_rows[i]);
    wait_drained();

    // Random part: per-button timelines so that holds and gaps land near the
    // tap window and the long-press threshold, plus raw noise polls.
    for (int i = 0; i < NumButtons; i++)
      btn_clock[i] = ($urandom_range(2) == 0) ? 32'hFFFF_0000 + $urandom_range(60000)
                                                : $urandom;
    last_b = '0;

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin lp = 16'd600;   win = 16'd250;   hold = 16'd0;     end
        1: begin lp = 16'd1;     win = 16'd0;     hold = 16'd0;     end
        2: begin lp = 16'hFFFF;  win = 16'hFFFF;  hold = 16'hFFFF;  end
        3: begin lp = 16'd400;   win = 16'd150;   hold = 16'd0;     end
        default: begin
          lp = CfgW'($urandom_range(3000, 1));
          win = CfgW'($urandom_range(800));
          hold = CfgW'($urandom_range(65535));
        end
      endcase
      apply_settings(lp, win, hold);

      // idling mix: none, sender-heavy, receiver-heavy, both moderate
      case (ph % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 85; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 85; end
        default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
      endcase
      // long receiver hold-off while polls keep coming: result queue fills
      // and the poll channel has to back-pressure
      if (ph == 0) rx_hold_left = RxHoldCycles;

      lp_i = int'(set_long);
      win_i = int'(set_window);
      for (int i = 0; i < PollsPerPhase; i++) begin
        // once, the sender pauses mid-phase until every gesture is out
        if (ph == 1 && i == PollsPerPhase / 2) wait_drained();

        r = $urandom_range(99);
        if (r < 85) begin
          b = ($urandom_range(3) != 0) ? last_b : BtnW'($urandom_range(NumButtons - 1));
          r = $urandom_range(99);
          if ($urandom_range(4) == 0) begin
            // same level again: only expiry checks
            lvl = lvl_prev[b];
            dt = $urandom_range(2 * win_i + 10);
          end else if (lvl_prev[b]) begin
            // press after a gap
            lvl = 1'b0;
            if (r < 50)      dt = $urandom_range(win_i);
            else if (r < 70) dt = win_i - 1 + int'($urandom_range(2));
            else             dt = win_i + int'($urandom_range(3000, 1));
          end else begin
            // release after a hold
            lvl = 1'b1;
            lim = (lp_i - 1 < win_i) ? lp_i - 1 : win_i;
            if (r < 50)      dt = $urandom_range(lim);
            else if (r < 65) dt = $urandom_range(lp_i - 1);
            else if (r < 85) dt = lp_i - 2 + int'($urandom_range(4));
            else             dt = lp_i + int'($urandom_range(5000));
          end
          if (dt < 0) dt = 0;
          t = btn_clock[b] + dt;
        end else begin
          // noise: any button and level at odd times
          b = BtnW'($urandom_range(NumButtons - 1));
          lvl = 1'($urandom_range(1));
          case ($urandom_range(4))
            0, 1: t = $urandom;
            2:    t = t_start + $urandom_range(int'(set_holdoff) + 10);
            3:    t = ($urandom_range(1) != 0) ? '1 : '0;
            default: t = btn_clock[b] - $urandom_range(500);
          endcase
        end
        btn_clock[b] = t;
        last_b = b;
        send_poll(mk_poll(b, lvl, t));
      end
      wait_drained();
    end

    if (due_gestures.size() != 0)
      flag_mismatch($sformatf("%0d gestures never came out", due_gestures.size()));

    $display("Ran %0d polls: directed rows, then %0d settings with idle/stall mixes",
             polls_sent, PhaseCount);
    $display("Checked %0d gestures: short %0d, double %0d, triple %0d, long %0d; %0d mismatches",
             gestures_seen, gesture_hist[GestShort], gesture_hist[GestDouble],
             gesture_hist[GestTriple], gesture_hist[GestLong], mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### multi_tap_press_classifier.f
rtl/core/mtpc_pkg.sv
rtl/core/mtpc_classify.sv
rtl/core/mtpc_res_fifo.sv
rtl/core/multi_tap_press_classifier.sv
test/multi_tap_press_classifier_tb.sv
